[rtl/fpfa_pkg.sv]
// Shared types, codes and sizing for the fixed-partition fit allocator.
// Used by fpfa_table, fpfa_scan, the top level and the checker; no dependencies.
package fpfa_pkg;

    // Table sizing
    localparam int MAX_PARTITIONS = 16;
    localparam int IDX_W  = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int CNT_W  = $clog2(MAX_PARTITIONS + 1);
    localparam int SIZE_W = 16;
    localparam int LBL_W  = 16;
    localparam int SLOT_W = 4;

    // Request kinds
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_ALLOC  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_NOFIT = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // Placement policies (any other code acts as first fit)
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    // Register map (word index)
    localparam logic REG_FIT_POLICY = 1'b0;

    // Commands into the partition table
    typedef struct packed {
        logic              clear;
        logic              append;
        logic [SIZE_W-1:0] size;
        logic [LBL_W-1:0]  label;
        logic              mark;
        logic [IDX_W-1:0]  mark_idx;
        logic [IDX_W-1:0]  rd_addr;
    } t_tbl_cmd;

    // Registered read data and status from the partition table
    typedef struct packed {
        logic [SIZE_W-1:0] rd_size;
        logic [LBL_W-1:0]  rd_label;
        logic              rd_in_use;
        logic [IDX_W-1:0]  rd_idx;
        logic [CNT_W-1:0]  count;
        logic              full;
    } t_tbl_rsp;

    // Outcome of one allocation scan
    typedef struct packed {
        logic              done;
        logic              found;
        logic [IDX_W-1:0]  pick;
        logic [LBL_W-1:0]  label;
    } t_scan_res;

endpackage

[rtl/fpfa_table.sv]
// Partition table: size/label memory with one registered read port,
// in-use marks and the fill count. Depends on fpfa_pkg.
module fpfa_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fpfa_pkg::t_tbl_cmd i_cmd,
    output fpfa_pkg::t_tbl_rsp o_rsp
);

    logic [fpfa_pkg::LBL_W+fpfa_pkg::SIZE_W-1:0] mem [fpfa_pkg::MAX_PARTITIONS];
    logic [fpfa_pkg::LBL_W+fpfa_pkg::SIZE_W-1:0] r_rd_data;
    logic [fpfa_pkg::IDX_W-1:0]                  r_rd_idx;
    logic [fpfa_pkg::MAX_PARTITIONS-1:0]         r_in_use;
    logic [fpfa_pkg::CNT_W-1:0]                  r_count;
    logic [fpfa_pkg::IDX_W-1:0]                  wr_idx;

    assign wr_idx = r_count[fpfa_pkg::IDX_W-1:0];

    // Write appended entries, read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            mem[wr_idx] <= {i_cmd.label, i_cmd.size};
        end
        r_rd_data <= mem[i_cmd.rd_addr];
        r_rd_idx  <= i_cmd.rd_addr;
    end

    // Track fill count and in-use marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_in_use <= '0;
        end else if (i_cmd.clear) begin
            r_count  <= '0;
            r_in_use <= '0;
        end else begin
            if (i_cmd.append) begin
                r_count          <= r_count + fpfa_pkg::CNT_W'(1);
                r_in_use[wr_idx] <= 1'b0;
            end
            if (i_cmd.mark) begin
                r_in_use[i_cmd.mark_idx] <= 1'b1;
            end
        end
    end

    assign o_rsp.rd_size   = r_rd_data[fpfa_pkg::SIZE_W-1:0];
    assign o_rsp.rd_label  = r_rd_data[fpfa_pkg::LBL_W+fpfa_pkg::SIZE_W-1:fpfa_pkg::SIZE_W];
    assign o_rsp.rd_in_use = r_in_use[r_rd_idx];
    assign o_rsp.rd_idx    = r_rd_idx;
    assign o_rsp.count     = r_count;
    assign o_rsp.full      = (r_count == fpfa_pkg::CNT_W'(fpfa_pkg::MAX_PARTITIONS));

endmodule

[rtl/fpfa_scan.sv]
// Allocation scan: walks the table one entry per cycle through a single
// compare unit and keeps the running pick. Depends on fpfa_pkg.
module fpfa_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fpfa_pkg::SIZE_W-1:0]   i_size,
    input  logic [1:0]                    i_policy,
    input  fpfa_pkg::t_tbl_rsp            i_rsp,
    output logic [fpfa_pkg::IDX_W-1:0]    o_rd_addr,
    output fpfa_pkg::t_scan_res           o_res
);

    logic                          r_issue;
    logic [fpfa_pkg::IDX_W-1:0]    r_idx;
    logic                          r_vld;
    logic                          r_last;
    logic                          r_done;
    logic                          r_found;
    logic [fpfa_pkg::IDX_W-1:0]    r_pick;
    logic [fpfa_pkg::SIZE_W-1:0]   r_best;
    logic [fpfa_pkg::LBL_W-1:0]    r_label;
    logic [fpfa_pkg::SIZE_W-1:0]   r_size;
    logic [1:0]                    r_policy;
    logic                          issue_last;
    logic                          fits;
    logic                          better;
    logic                          take;

    // Last entry to read is count-1
    assign issue_last = ((fpfa_pkg::CNT_W'(r_idx) + fpfa_pkg::CNT_W'(1)) == i_rsp.count);
    assign o_rd_addr  = r_idx;

    // Shared compare unit: fit test and policy ordering against the running pick
    always_comb begin
        fits = !i_rsp.rd_in_use && (i_rsp.rd_size >= r_size);
        case (r_policy)
            fpfa_pkg::POL_BEST:  better = !r_found || (i_rsp.rd_size < r_best);
            fpfa_pkg::POL_WORST: better = !r_found || (i_rsp.rd_size > r_best);
            default:             better = !r_found;
        endcase
        take = r_vld && fits && better;
    end

    // Sequence reads and track the pick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_idx   <= '0;
            r_vld   <= 1'b0;
            r_last  <= 1'b0;
            r_done  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_vld  <= r_issue;
            r_last <= r_issue && issue_last;
            r_done <= r_vld && r_last;
            if (i_start) begin
                r_issue <= 1'b1;
                r_idx   <= '0;
                r_found <= 1'b0;
            end else begin
                if (r_issue) begin
                    if (issue_last) begin
                        r_issue <= 1'b0;
                    end else begin
                        r_idx <= r_idx + fpfa_pkg::IDX_W'(1);
                    end
                end
                if (take) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    // Latch request and pick payload
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_size   <= i_size;
            r_policy <= i_policy;
        end
        if (take) begin
            r_pick  <= i_rsp.rd_idx;
            r_best  <= i_rsp.rd_size;
            r_label <= i_rsp.rd_label;
        end
    end

    assign o_res.done  = r_done;
    assign o_res.found = r_found;
    assign o_res.pick  = r_pick;
    assign o_res.label = r_label;

endmodule

[rtl/fixed_partition_fit_allocator.sv]
// Top level of the fixed-partition fit allocator: request intake, APB policy
// register, result register. Depends on fpfa_pkg, fpfa_table, fpfa_scan.
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the request kind
//   (clear, append, allocate), tdata the size and the label. Results leave on
//   m_axis: tuser carries the status, tdata the granted label and slot.
//   The placement policy (first, best, worst fit) is written over APB at
//   address 0 while the block is idle.
//   Clear, append and unused kinds need no scan: the result shows on
//   m_axis the cycle after the request is taken.
//   An allocation reads the table one entry per cycle through a single
//   compare unit; its outcome then passes through the commit state into
//   the result register. An empty table answers like a clear, without a scan.
//   s_axis_tready is low while a scan runs.
//   Reset empties the table, clears all in-use marks and selects first fit.
//   When the receiver stalls, the result holds in the output register; a new
//   request is taken only when that register is free or being emptied.
module fixed_partition_fit_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] size_value, [31:16] block_label
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    // Result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] granted_label, [19:16] granted_slot
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0]                    r_state;
    logic [1:0]                    n_state;
    logic [1:0]                    r_policy;
    logic                          r_out_vld;
    logic                          n_out_vld;
    logic [1:0]                    r_out_status;
    logic [1:0]                    n_out_status;
    logic [fpfa_pkg::LBL_W-1:0]    r_out_label;
    logic [fpfa_pkg::LBL_W-1:0]    n_out_label;
    logic [fpfa_pkg::SLOT_W-1:0]   r_out_slot;
    logic [fpfa_pkg::SLOT_W-1:0]   n_out_slot;
    logic                          out_free;
    logic                          in_take;
    logic                          load;
    logic                          scan_start;
    fpfa_pkg::t_tbl_cmd            tbl_cmd;
    fpfa_pkg::t_tbl_rsp            tbl_rsp;
    fpfa_pkg::t_scan_res           scan_res;
    logic [fpfa_pkg::IDX_W-1:0]    scan_addr;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == fpfa_pkg::REG_FIT_POLICY) ? {30'd0, r_policy} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= fpfa_pkg::POL_FIRST;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == fpfa_pkg::REG_FIT_POLICY)) begin
            r_policy <= pwdata[1:0];
        end
    end

    // Handshake
    assign out_free      = !r_out_vld || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Dispatch requests, commit scan outcomes
    always_comb begin
        n_state       = r_state;
        load          = 1'b0;
        scan_start    = 1'b0;
        n_out_status  = fpfa_pkg::ST_DONE;
        n_out_label   = '0;
        n_out_slot    = '0;
        tbl_cmd.clear    = 1'b0;
        tbl_cmd.append   = 1'b0;
        tbl_cmd.size     = s_axis_tdata[15:0];
        tbl_cmd.label    = s_axis_tdata[31:16];
        tbl_cmd.mark     = 1'b0;
        tbl_cmd.mark_idx = scan_res.pick;
        tbl_cmd.rd_addr  = scan_addr;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    case (s_axis_tuser)
                        fpfa_pkg::REQ_CLEAR: begin
                            tbl_cmd.clear = 1'b1;
                            load          = 1'b1;
                        end
                        fpfa_pkg::REQ_APPEND: begin
                            load = 1'b1;
                            if (tbl_rsp.full) begin
                                n_out_status = fpfa_pkg::ST_FULL;
                            end else begin
                                tbl_cmd.append = 1'b1;
                            end
                        end
                        fpfa_pkg::REQ_ALLOC: begin
                            if (tbl_rsp.count == '0) begin
                                load         = 1'b1;
                                n_out_status = fpfa_pkg::ST_NOFIT;
                            end else begin
                                scan_start = 1'b1;
                                n_state    = S_SCAN;
                            end
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_res.done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                    if (scan_res.found) begin
                        tbl_cmd.mark = 1'b1;
                        n_out_status = fpfa_pkg::ST_ALLOC;
                        n_out_label  = scan_res.label;
                        n_out_slot   = fpfa_pkg::SLOT_W'(scan_res.pick);
                    end else begin
                        n_out_status = fpfa_pkg::ST_NOFIT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (load) begin
            n_out_vld = 1'b1;
        end else if (m_axis_tready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    // Hold result payload until loaded again
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_status <= n_out_status;
            r_out_label  <= n_out_label;
            r_out_slot   <= n_out_slot;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {4'd0, r_out_slot, r_out_label};

    fpfa_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tbl_cmd),
        .o_rsp   (tbl_rsp)
    );

    fpfa_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (scan_start),
        .i_size    (s_axis_tdata[15:0]),
        .i_policy  (r_policy),
        .i_rsp     (tbl_rsp),
        .o_rd_addr (scan_addr),
        .o_res     (scan_res)
    );

endmodule

[rtl/fpfa_checker.sv]
// Port-level checks for the fixed-partition fit allocator, bound to the top.
// Depends on fpfa_pkg.
module fpfa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A stalled result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

    // Label and slot are zero unless a partition was granted
    a_zero_unless_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != fpfa_pkg::ST_ALLOC) |-> m_axis_tdata == 24'd0)
        else $error("nonzero grant fields without allocation");

    // Non-allocation requests answer in the next cycle
    a_quick_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != fpfa_pkg::REQ_ALLOC)
        |=> m_axis_tvalid)
        else $error("clear or append result missing");

    // No result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind fixed_partition_fit_allocator fpfa_checker u_fpfa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[bench/testbench.sv]
// Self-checking bench for fixed_partition_fit_allocator: directed and random requests
// on the stream ports, policy writes over APB, in-bench prediction of every result.
// Depends on fpfa_pkg and the allocator RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Codes the package leaves unnamed
    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam logic [1:0] POL_UNUSED   = 2'd3;
    localparam logic [2:0] POLICY_ADDR  = 3'(4 * fpfa_pkg::REG_FIT_POLICY);
    localparam int         MAX_REPORTS  = 10;

    typedef struct {
        logic [1:0]                  status;
        logic [fpfa_pkg::LBL_W-1:0]  label;
        logic [fpfa_pkg::SLOT_W-1:0] slot;
    } t_grant;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [15:0] size_value, [31:16] block_label
    logic [1:0]  s_axis_tuser;   // [1:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [15:0] granted_label, [19:16] granted_slot
    logic [1:0]  m_axis_tuser;   // [1:0] status
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fixed_partition_fit_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Shadow copy of the partition table and the policy register
    logic [fpfa_pkg::SIZE_W-1:0]         shadow_size  [fpfa_pkg::MAX_PARTITIONS];
    logic [fpfa_pkg::LBL_W-1:0]          shadow_label [fpfa_pkg::MAX_PARTITIONS];
    logic [fpfa_pkg::MAX_PARTITIONS-1:0] shadow_in_use;
    int                                  shadow_count;
    logic [1:0]                          shadow_policy;

    t_grant pending_grants[$];

    bit idle_en;
    int n_requests;
    int n_granted;
    int n_nofit;
    int n_full;
    int n_policy_writes;
    int n_mismatch;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // Randomly stall the result channel
    always @(posedge i_clk) begin
        m_axis_tready <= !(idle_en && ($urandom_range(0, 99) < 33));
    end

    task automatic note_mismatch(input string what);
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS) begin
            $display("%0t: mismatch: %s", $realtime, what);
        end
    endtask

    // Compare each taken result with the oldest prediction
    always @(posedge i_clk) begin
        t_grant exp_g;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_grants.size() == 0) begin
                note_mismatch($sformatf("result with nothing pending: status %0d label %h slot %0d",
                                        m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[19:16]));
            end else begin
                exp_g = pending_grants.pop_front();
                if (m_axis_tuser !== exp_g.status || m_axis_tdata[15:0] !== exp_g.label ||
                    m_axis_tdata[19:16] !== exp_g.slot) begin
                    note_mismatch($sformatf(
                        "expected status %0d label %h slot %0d, got status %0d label %h slot %0d",
                        exp_g.status, exp_g.label, exp_g.slot,
                        m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[19:16]));
                end
            end
        end
    end

    // Apply one request to the shadow table and return the result it must give
    function automatic t_grant predict_grant(input logic [1:0] kind,
                                             input logic [fpfa_pkg::SIZE_W-1:0] sz,
                                             input logic [fpfa_pkg::LBL_W-1:0] lbl);
        t_grant g;
        bit     found;
        bit     stop;
        int     pick;
        g     = '{status: fpfa_pkg::ST_DONE, label: '0, slot: '0};
        found = 1'b0;
        stop  = 1'b0;
        pick  = 0;
        case (kind)
            fpfa_pkg::REQ_CLEAR: begin
                shadow_count  = 0;
                shadow_in_use = '0;
            end
            fpfa_pkg::REQ_APPEND: begin
                if (shadow_count >= fpfa_pkg::MAX_PARTITIONS) begin
                    g.status = fpfa_pkg::ST_FULL;
                end else begin
                    shadow_size[shadow_count]   = sz;
                    shadow_label[shadow_count]  = lbl;
                    shadow_in_use[shadow_count] = 1'b0;
                    shadow_count++;
                end
            end
            fpfa_pkg::REQ_ALLOC: begin
                // Scan in table order; first fit stops at the first candidate
                for (int i = 0; i < shadow_count; i++) begin
                    if (!stop && !shadow_in_use[i] && shadow_size[i] >= sz) begin
                        if (!found) begin
                            found = 1'b1;
                            pick  = i;
                            stop  = (shadow_policy != fpfa_pkg::POL_BEST) &&
                                    (shadow_policy != fpfa_pkg::POL_WORST);
                        end else if (shadow_policy == fpfa_pkg::POL_BEST) begin
                            if (shadow_size[i] < shadow_size[pick]) pick = i;
                        end else if (shadow_policy == fpfa_pkg::POL_WORST) begin
                            if (shadow_size[i] > shadow_size[pick]) pick = i;
                        end
                    end
                end
                if (found) begin
                    shadow_in_use[pick] = 1'b1;
                    g.status = fpfa_pkg::ST_ALLOC;
                    g.label  = shadow_label[pick];
                    g.slot   = fpfa_pkg::SLOT_W'(pick);
                end else begin
                    g.status = fpfa_pkg::ST_NOFIT;
                end
            end
            default: ;
        endcase
        return g;
    endfunction

    // Send one request; tvalid stays high afterwards until the next gap or pause
    task automatic send_request(input logic [1:0] kind,
                                input logic [fpfa_pkg::SIZE_W-1:0] sz,
                                input logic [fpfa_pkg::LBL_W-1:0] lbl);
        t_grant g;
        while (idle_en && ($urandom_range(0, 99) < 33)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {lbl, sz};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        g = predict_grant(kind, sz, lbl);
        pending_grants.push_back(g);
        n_requests++;
        case (g.status)
            fpfa_pkg::ST_ALLOC: n_granted++;
            fpfa_pkg::ST_NOFIT: n_nofit++;
            fpfa_pkg::ST_FULL:  n_full++;
            default: ;
        endcase
    endtask

    // Drop tvalid and hold until every pending result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the policy register, then read it back
    task automatic set_policy(input logic [1:0] pol);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= POLICY_ADDR;
        pwdata  <= 32'(pol);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow_policy = pol;
        n_policy_writes++;
        // back-to-back read access
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[1:0] !== pol) begin
            note_mismatch($sformatf("policy readback expected %0d, got %0d", pol, prdata[1:0]));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Size drawn to hit zero, the maximum and frequent ties
    function automatic logic [fpfa_pkg::SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 6)  return fpfa_pkg::SIZE_W'($urandom_range(0, 8) * 16);
        return fpfa_pkg::SIZE_W'($urandom);
    endfunction

    // Extreme sizes and labels, zero-size request, no fit, unused kind
    task automatic test_first_fit_basics();
        send_request(fpfa_pkg::REQ_CLEAR, 16'h0000, 16'h0000);
        send_request(fpfa_pkg::REQ_APPEND, 16'hFFFF, 16'hFFFF);
        send_request(fpfa_pkg::REQ_APPEND, 16'h0000, 16'h0000);
        send_request(fpfa_pkg::REQ_APPEND, 16'd300, 16'h1234);
        send_request(fpfa_pkg::REQ_ALLOC, 16'h0000, 16'hA5A5);
        send_request(fpfa_pkg::REQ_ALLOC, 16'hFFFF, 16'h0000);
        send_request(fpfa_pkg::REQ_ALLOC, 16'd200, 16'h0000);
        send_request(REQ_UNUSED, 16'hFFFF, 16'hFFFF);
        wait_drained();
    endtask

    // Best and worst fit with equal sizes, then the unused policy code
    task automatic test_policy_ties();
        set_policy(fpfa_pkg::POL_BEST);
        send_request(fpfa_pkg::REQ_APPEND, 16'd40, 16'h0040);
        send_request(fpfa_pkg::REQ_APPEND, 16'd20, 16'h0020);
        send_request(fpfa_pkg::REQ_APPEND, 16'd20, 16'h0021);
        send_request(fpfa_pkg::REQ_APPEND, 16'd60, 16'h0060);
        send_request(fpfa_pkg::REQ_ALLOC, 16'd10, 16'h0000);
        wait_drained();
        set_policy(fpfa_pkg::POL_WORST);
        send_request(fpfa_pkg::REQ_ALLOC, 16'd10, 16'h0000);
        send_request(fpfa_pkg::REQ_ALLOC, 16'd10, 16'h0000);
        wait_drained();
        set_policy(POL_UNUSED);
        send_request(fpfa_pkg::REQ_ALLOC, 16'd10, 16'h0000);
        send_request(fpfa_pkg::REQ_ALLOC, 16'd0, 16'h0000);
        wait_drained();
    endtask

    // Fill the table and append once more
    task automatic test_full_table();
        while (shadow_count < fpfa_pkg::MAX_PARTITIONS) begin
            send_request(fpfa_pkg::REQ_APPEND, pick_size(), 16'($urandom));
        end
        send_request(fpfa_pkg::REQ_APPEND, 16'($urandom), 16'($urandom));
        wait_drained();
    endtask

    // Clear, fill with random partitions, then allocate; some noise mixed in
    task automatic test_random_tables(input int n_items);
        int start;
        int n_parts;
        int n_allocs;
        start = n_requests;
        while (n_requests - start < n_items) begin
            if ($urandom_range(0, 3) == 0) begin
                wait_drained();
                set_policy(2'($urandom_range(0, 3)));
            end
            send_request(fpfa_pkg::REQ_CLEAR, 16'($urandom), 16'($urandom));
            n_parts = $urandom_range(0, fpfa_pkg::MAX_PARTITIONS + 1);
            for (int i = 0; i < n_parts; i++) begin
                send_request(fpfa_pkg::REQ_APPEND, pick_size(), 16'($urandom));
            end
            n_allocs = $urandom_range(1, n_parts + 3);
            for (int i = 0; i < n_allocs; i++) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_request(2'($urandom), 16'($urandom), 16'($urandom));
                end else begin
                    send_request(fpfa_pkg::REQ_ALLOC, pick_size(), 16'($urandom));
                end
            end
            // occasionally pause the sender until everything is back
            if ($urandom_range(0, 7) == 0) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tuser   <= fpfa_pkg::REQ_CLEAR;
        m_axis_tready  <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        idle_en         = 1'b1;
        shadow_count    = 0;
        shadow_in_use   = '0;
        shadow_policy   = fpfa_pkg::POL_FIRST;
        n_requests      = 0;
        n_granted       = 0;
        n_nofit         = 0;
        n_full          = 0;
        n_policy_writes = 0;
        n_mismatch      = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_first_fit_basics();
        test_policy_ties();
        test_full_table();
        // stretch with no gaps or stalls on either side
        idle_en = 1'b0;
        test_random_tables(80);
        idle_en = 1'b1;
        test_random_tables(320);
        repeat (30) @(posedge i_clk);

        $display("covered %0d requests: %0d grants, %0d no-fit, %0d table-full",
                 n_requests, n_granted, n_nofit, n_full);
        $display("over %0d policy writes, with gaps and stalls on both channels",
                 n_policy_writes);
        if (n_mismatch == 0 && pending_grants.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
